>>> hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// Ready table package
// Shared constants and types for the aging ready table.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_AGE      = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [15:0] AGING_RESET = 16'd100;
  localparam logic [15:0] ACCUM_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [19:0] remaining;
    logic [15:0] accum;
    logic [31:0] last_check;
  } entry_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic        ring;      // rotate the whole row by one position
    logic        age_step;  // run one aging subtract step in every cell that can step
    logic        age_load;  // fold elapsed time into the accumulator
    logic [31:0] now_time;
    logic [15:0] interval;
  } cell_ctrl_t;

endpackage

>>> hdl/pst_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying a payload type.
// ----------------------------------------------------------------------------
interface pst_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pst_cell.sv
// ----------------------------------------------------------------------------
// Ready table cell
// One table slot. Takes its neighbor's entry on a rotate and ages itself.
// ----------------------------------------------------------------------------
module pst_cell import pst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  entry_t     entry_i,
  input  logic       load_i,
  input  logic       load_valid_i,
  input  entry_t     load_entry_i,
  output logic       valid_o,
  output entry_t     entry_o,
  output logic       step_ok_o
);

  logic        valid_q, valid_d;
  logic        active_q, active_d;
  entry_t      entry_q, entry_d;
  logic [32:0] work_q, work_d;
  logic [31:0] elapsed;
  logic        step_ok;

  assign elapsed = ctrl_i.now_time - entry_q.last_check;

  // The working total holds the waiting time, less the intervals already stepped off, while an age item steps.
  assign step_ok = active_q && valid_q && ctrl_i.interval != '0 &&
                   entry_q.prio != '0 && work_q >= {17'd0, ctrl_i.interval};

  always_comb begin
    valid_d  = valid_q;
    active_d = active_q;
    entry_d  = entry_q;
    work_d   = work_q;
    if (load_i) begin
      valid_d  = load_valid_i;
      entry_d  = load_entry_i;
      active_d = 1'b0;
    end else if (ctrl_i.ring) begin
      valid_d  = valid_i;
      entry_d  = entry_i;
      active_d = 1'b0;
    end else if (ctrl_i.age_load) begin
      active_d = 1'b0;
      if (valid_q && ctrl_i.now_time > entry_q.last_check) begin
        active_d = 1'b1;
        work_d   = {17'd0, entry_q.accum} + {1'b0, elapsed};
        entry_d.last_check = ctrl_i.now_time;
        // With a zero interval the priority drops straight to zero.
        if (ctrl_i.interval == '0) entry_d.prio = '0;
        entry_d.accum = (work_d[32:16] != '0) ? ACCUM_MAX : work_d[15:0];
      end
    end else if (ctrl_i.age_step && step_ok) begin
      work_d        = work_q - {17'd0, ctrl_i.interval};
      entry_d.prio  = entry_q.prio - 8'd1;
      entry_d.accum = (work_d[32:16] != '0) ? ACCUM_MAX : work_d[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    work_q  <= work_d;
  end

  assign valid_o   = valid_q;
  assign entry_o   = entry_q;
  assign step_ok_o = step_ok;

endmodule

>>> hdl/priority_srtf_ready_table_with_aging.sv
// ----------------------------------------------------------------------------
// Priority ready table with aging
// Row of cells holding tasks in arrival order; insert, age and dispatch.
// ----------------------------------------------------------------------------
// Entries sit in a row of cells in arrival order. An insert, an unused
// command and a dispatch on an empty table are answered from the idle
// state. A dispatch rotates the ring once fully to find the best entry
// (lowest priority, then least remaining, then oldest), then shifts the
// cells above the chosen one down by one and writes the result.
// An age item folds the elapsed time into every valid cell whose time has
// moved forward in the cycle it is taken, then runs one subtract step per
// cycle in every cell that can step (one priority level each) until no
// cell can step, at most 255 steps, and then writes the result. A new item
// is taken only when the result register is empty or being read in that cycle.
module priority_srtf_ready_table_with_aging import pst_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  pst_if.sink   in_ch,
  pst_if.sink   cfg_ch,
  pst_if.source out_ch
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGE  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [15:0]   interval_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [IW-1:0] best_q, best_d;
  entry_t        best_e_q, best_e_d;
  logic [8:0]    steps_q, steps_d;
  logic [31:0]   now_q;
  logic [1:0]    res_st_d;
  entry_t        res_e_d;
  logic          res_go;
  logic          out_valid_q;
  logic [1:0]    out_st_q;
  entry_t        out_e_q;

  cell_ctrl_t ctrl;
  logic   cv [TABLE_DEPTH];
  entry_t ce [TABLE_DEPTH];
  logic   ld [TABLE_DEPTH];
  logic   sok [TABLE_DEPTH];
  logic   any_step;
  logic   shift_on;
  entry_t head;

  assign shift_on = (state_q == S_SHIFT);

  // Ring: cell k takes from cell k+1, last takes from cell 0.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    localparam int NX = (k + 1) % TABLE_DEPTH;
    entry_t new_e;
    assign new_e = '{id: in_ch.data.task_id, prio: in_ch.data.task_priority,
                     remaining: in_ch.data.task_remaining, accum: '0,
                     last_check: in_ch.data.now_time};
    pst_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .valid_i(cv[NX]), .entry_i(ce[NX]),
      .load_i(ld[k]),
      .load_valid_i(shift_on ? ((k == TABLE_DEPTH - 1) ? 1'b0 : cv[NX]) : 1'b1),
      .load_entry_i(shift_on ? ce[NX] : new_e),
      .valid_o(cv[k]), .entry_o(ce[k]), .step_ok_o(sok[k])
    );
  end

  assign head = ce[0];

  always_comb begin
    any_step = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (sok[k]) any_step = 1'b1;
    end
  end

  assign in_ch.ready  = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    best_d   = best_q;
    best_e_d = best_e_q;
    steps_d  = steps_q;
    res_go   = 1'b0;
    res_st_d = ST_DONE;
    res_e_d  = '0;
    ctrl.ring     = 1'b0;
    ctrl.age_step = 1'b0;
    ctrl.age_load = 1'b0;
    ctrl.now_time = now_q;
    ctrl.interval = interval_q;
    for (int k = 0; k < TABLE_DEPTH; k++) ld[k] = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          unique case (in_ch.data.cmd)
            CMD_INSERT: begin
              res_go = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                res_st_d = ST_FULL;
              end else begin
                ld[count_q[IW-1:0]] = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_AGE: begin
              ctrl.now_time = in_ch.data.now_time;
              ctrl.age_load = 1'b1;
              steps_d = '0;
              state_d = S_AGE;
            end
            CMD_DISPATCH: begin
              if (count_q == '0) begin
                res_go   = 1'b1;
                res_st_d = ST_EMPTY;
              end else begin
                pos_d    = '0;
                best_d   = '0;
                best_e_d = '0;
                state_d  = S_SCAN;
              end
            end
            default: res_go = 1'b1;
          endcase
        end
      end
      S_AGE: begin
        if (any_step && steps_q != 9'd256) begin
          ctrl.age_step = 1'b1;
          steps_d = steps_q + 1'b1;
        end else begin
          res_go  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // Head cell holds logical slot pos_q; full rotation restores order.
        if (pos_q < count_q && (pos_q == '0 || head.prio < best_e_q.prio ||
            (head.prio == best_e_q.prio && head.remaining < best_e_q.remaining))) begin
          best_d   = pos_q[IW-1:0];
          best_e_d = head;
        end
        ctrl.ring = 1'b1;
        pos_d = pos_q + 1'b1;
        if (pos_q == CW'(TABLE_DEPTH - 1)) begin
          pos_d   = '0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Cells from the chosen slot upward take their upper neighbor.
        for (int k = 0; k < TABLE_DEPTH; k++) ld[k] = (IW'(k) >= best_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        res_go   = 1'b1;
        res_e_d  = best_e_q;
        count_d  = count_q - 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      interval_q  <= AGING_RESET;
      count_q     <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      steps_q <= steps_d;
      if (cfg_ch.valid && cfg_ch.ready) interval_q <= cfg_ch.data;
      if (res_go) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    best_e_q <= best_e_d;
    if (in_ch.valid && in_ch.ready) now_q <= in_ch.data.now_time;
    if (res_go) begin
      out_st_q <= res_st_d;
      out_e_q  <= res_e_d;
    end
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.data.status        = out_st_q;
  assign out_ch.data.out_id        = out_e_q.id;
  assign out_ch.data.out_priority  = out_e_q.prio;
  assign out_ch.data.out_remaining = out_e_q.remaining;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ch.ready) else $error("took item while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> out_valid_q) else $error("result lost");
`endif

endmodule

>>> bench/tb_priority_srtf_ready_table_with_aging.sv
// ----------------------------------------------------------------------------
// Ready table testbench
// Sends insert, age and dispatch items with random gaps and back-pressure.
// Every result is checked against a scoreboard table that tracks aging and
// the dispatch order. The aging interval is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_priority_srtf_ready_table_with_aging;
  import pst_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_time;
    logic [15:0] task_id;
    logic [7:0]  task_priority;
    logic [19:0] task_remaining;
  } task_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [19:0] out_remaining;
  } sched_result_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pst_if #(.T(task_item_t))    cmd_ch ();
  pst_if #(.T(logic [15:0]))   cfg_ch ();
  pst_if #(.T(sched_result_t)) res_ch ();

  priority_srtf_ready_table_with_aging #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (cmd_ch),
    .cfg_ch (cfg_ch),
    .out_ch (res_ch)
  );

  always #1 clk_i = ~clk_i;

  // Scoreboard copy of the ready table.
  logic [15:0] sb_id [DEPTH];
  logic [7:0]  sb_prio [DEPTH];
  logic [19:0] sb_rem [DEPTH];
  logic [15:0] sb_accum [DEPTH];
  logic [31:0] sb_last [DEPTH];
  int          sb_count = 0;
  logic [15:0] sb_interval = AGING_RESET;

  task_item_t    task_queue [$];
  logic [15:0]   interval_queue [$];
  sched_result_t expected_results [$];
  int            mismatches = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  bit            calm = 1'b0;
  logic [31:0]   sim_clock = 32'd0;

  function automatic sched_result_t schedule_step(task_item_t it);
    sched_result_t r;
    int best;
    longint unsigned total;
    longint unsigned steps;
    longint unsigned dec;
    r = '0;
    case (it.cmd)
      CMD_INSERT: begin
        if (sb_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          sb_id[sb_count]    = it.task_id;
          sb_prio[sb_count]  = it.task_priority;
          sb_rem[sb_count]   = it.task_remaining;
          sb_accum[sb_count] = '0;
          sb_last[sb_count]  = it.now_time;
          sb_count++;
        end
      end
      CMD_AGE: begin
        for (int i = 0; i < sb_count; i++) begin
          if (it.now_time > sb_last[i]) begin
            total = 64'(sb_accum[i]) + 64'(it.now_time - sb_last[i]);
            sb_last[i] = it.now_time;
            if (sb_interval == 0) begin
              dec = sb_prio[i];
            end else begin
              steps = total / sb_interval;
              dec = (steps < sb_prio[i]) ? steps : 64'(sb_prio[i]);
              total -= dec * sb_interval;
            end
            sb_prio[i]  = sb_prio[i] - 8'(dec);
            sb_accum[i] = (total > 64'(ACCUM_MAX)) ? ACCUM_MAX : 16'(total);
          end
        end
      end
      CMD_DISPATCH: begin
        if (sb_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < sb_count; i++) begin
            if (sb_prio[i] < sb_prio[best] ||
                (sb_prio[i] == sb_prio[best] && sb_rem[i] < sb_rem[best]))
              best = i;
          end
          r.out_id        = sb_id[best];
          r.out_priority  = sb_prio[best];
          r.out_remaining = sb_rem[best];
          for (int i = best; i + 1 < sb_count; i++) begin
            sb_id[i]    = sb_id[i+1];
            sb_prio[i]  = sb_prio[i+1];
            sb_rem[i]   = sb_rem[i+1];
            sb_accum[i] = sb_accum[i+1];
            sb_last[i]  = sb_last[i+1];
          end
          sb_count--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Command driver: the scoreboard is updated as each item is accepted.
  int cmd_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(schedule_step(cmd_ch.data));
        void'(task_queue.pop_front());
        cmd_gap = pick_gap();
      end
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (task_queue.size() != 0) begin
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= task_queue[0];
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Interval register writer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch.valid <= 1'b0;
      cfg_ch.data  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb_interval = cfg_ch.data;
        void'(interval_queue.pop_front());
      end
      if (interval_queue.size() != 0) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= interval_queue[0];
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random and requested long stalls.
  int res_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (holds_served < hold_requests) begin
        holds_served++;
        res_stall = 2000;
      end
      r = $urandom_range(0, 99);
      if (res_stall > 0) begin
        res_stall--;
        res_ch.ready <= 1'b0;
      end else if (!calm && r < 20) begin
        res_stall = (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_ch.data), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (res_ch.data.status !== want.status)
          report_mismatch("status", 32'(res_ch.data.status), 32'(want.status));
        if (res_ch.data.out_id !== want.out_id)
          report_mismatch("out_id", 32'(res_ch.data.out_id), 32'(want.out_id));
        if (res_ch.data.out_priority !== want.out_priority)
          report_mismatch("out_priority", 32'(res_ch.data.out_priority),
                          32'(want.out_priority));
        if (res_ch.data.out_remaining !== want.out_remaining)
          report_mismatch("out_remaining", 32'(res_ch.data.out_remaining),
                          32'(want.out_remaining));
      end
    end
  end

  function automatic task_item_t make_item(logic [1:0] cmd, logic [31:0] now,
                                           logic [15:0] id, logic [7:0] prio,
                                           logic [19:0] rem);
    task_item_t it;
    it.cmd = cmd;
    it.now_time = now;
    it.task_id = id;
    it.task_priority = prio;
    it.task_remaining = rem;
    return it;
  endfunction

  // Mostly a clock that moves forward; sometimes stalled, stepped back or far ahead.
  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) sim_clock += $urandom_range(0, 400);
    else if (r < 86) sim_clock += 0;
    else if (r < 92) return sim_clock - $urandom_range(1, 1000);
    else if (r < 97) sim_clock += $urandom_range(1000, 300000);
    else sim_clock = $urandom();
    return sim_clock;
  endfunction

  // Fill mode favors inserts so the table reaches full; drain mode favors dispatch.
  function automatic task_item_t random_item(bit fill_mode);
    int r;
    logic [1:0] cmd;
    logic [7:0] prio;
    logic [19:0] rem;
    r = $urandom_range(0, 99);
    if (fill_mode) cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_AGE :
                         (r < 97) ? CMD_DISPATCH : CMD_UNUSED;
    else           cmd = (r < 25) ? CMD_INSERT : (r < 45) ? CMD_AGE :
                         (r < 97) ? CMD_DISPATCH : CMD_UNUSED;
    prio = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 6));
    rem  = ($urandom_range(0, 2) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 7));
    return make_item(cmd, next_time(), 16'($urandom()), prio, rem);
  endfunction

  task automatic wait_idle();
    while (task_queue.size() != 0 || interval_queue.size() != 0 ||
           expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] intervals [6];
    intervals = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd100, 16'($urandom())};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset interval.
    task_queue.push_back(make_item(CMD_DISPATCH, 32'd0, 16'd0, 8'd0, 20'd0));
    task_queue.push_back(make_item(CMD_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 20'hFFFFF));
    task_queue.push_back(make_item(CMD_INSERT, 32'd16, 16'hFFFF, 8'hFF, 20'hFFFFF));
    task_queue.push_back(make_item(CMD_INSERT, 32'd32, 16'h0000, 8'h00, 20'h00000));
    task_queue.push_back(make_item(CMD_INSERT, 32'd48, 16'd5, 8'd10, 20'd50));
    task_queue.push_back(make_item(CMD_INSERT, 32'd64, 16'd6, 8'd10, 20'd50));
    task_queue.push_back(make_item(CMD_INSERT, 32'd80, 16'd7, 8'd10, 20'd20));
    task_queue.push_back(make_item(CMD_AGE, 32'd64, 16'd0, 8'd0, 20'd0));
    task_queue.push_back(make_item(CMD_AGE, 32'd10, 16'd0, 8'd0, 20'd0));
    task_queue.push_back(make_item(CMD_AGE, 32'd1080, 16'd0, 8'd0, 20'd0));
    // A huge step drives the zero-priority entries into accumulator saturation.
    task_queue.push_back(make_item(CMD_AGE, 32'hFFFFFFFF, 16'd0, 8'd0, 20'd0));
    repeat (6) task_queue.push_back(make_item(CMD_DISPATCH, 32'd0, 16'd0, 8'd0, 20'd0));
    wait_idle();

    foreach (intervals[p]) begin
      wait_idle();
      // Let the block sit idle for a while before the register changes.
      repeat (600) @(negedge clk_i);
      interval_queue.push_back(intervals[p]);
      wait_idle();
      calm = (p == 3);
      for (int k = 0; k < 255; k++) begin
        task_queue.push_back(random_item((k / 45) % 2 == 0));
        if (p == 1 && k == 60) hold_requests++;
        if (p == 2 && k == 120) wait_idle();
        while (task_queue.size() > 8) @(negedge clk_i);
      end
    end
    wait_idle();
    repeat (600) @(negedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/pst_pkg.sv
hdl/pst_if.sv
hdl/pst_cell.sv
hdl/priority_srtf_ready_table_with_aging.sv
bench/tb_priority_srtf_ready_table_with_aging.sv
